@@ hdl/lifo_stack_with_reverse_defines.svh @@
// Assertion macros used by the stack RTL.
// Each macro expects aclk and aresetn in scope; no other dependencies.
`ifndef LIFO_STACK_WITH_REVERSE_DEFINES_SVH
`define LIFO_STACK_WITH_REVERSE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lsr_pkg.sv @@
// Shared constants and codes for the LIFO stack with in-place reverse.
// No dependencies; used by lifo_stack_with_reverse.
`default_nettype none

package lsr_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;

    // Fixed field widths of the stream channels
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;
    localparam int M_TDATA_W     = ((WORD_W + ENTRY_COUNT_W + 7) / 8) * 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

`default_nettype wire

@@ hdl/lifo_stack_with_reverse.sv @@
// LIFO stack of signed 32-bit words with push, pop and in-place reverse.
// Push, empty pop and unknown codes load the result register directly; a pop reads the RAM first.
// Reverse of n entries swaps the outer pairs inward, one word at a time over the single RAM write port.
// Throughput: one beat at a time; s_tready is high only while idle with the output register free.
// Reset (aresetn low, synchronous) empties the stack; RAM contents are not cleared.
`default_nettype none
`include "lifo_stack_with_reverse_defines.svh"

module lifo_stack_with_reverse (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Request channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lsr_pkg::WORD_W-1:0]       s_tdata,  // [31:0] push_value
    input  wire logic [lsr_pkg::REQ_W-1:0]        s_tuser,  // [1:0] req_type
    // Result channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [lsr_pkg::M_TDATA_W-1:0]    m_tdata,  // [31:0] pop_value,
                                                            // [36:32] entry_count,
                                                            // [39:37] zero
    output logic      [lsr_pkg::STATUS_W-1:0]     m_tuser   // [1:0] status
);

    localparam int ADDR_W = lsr_pkg::ADDR_W;
    localparam int CNT_W  = lsr_pkg::CNT_W;
    localparam int WORD_W = lsr_pkg::WORD_W;

    // One-hot sequencer states
    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_POP_WAIT = 5'b00010,
        ST_REV_STEP = 5'b00100,
        ST_REV_WLO  = 5'b01000,
        ST_REV_WHI  = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              lo_reg, lo_next;
    logic [CNT_W-1:0]              hi_reg, hi_next;

    // Output register: holds a finished result until the sink takes the beat
    logic                          m_valid_reg;
    logic [WORD_W-1:0]             pop_value_reg;
    logic [lsr_pkg::STATUS_W-1:0]  status_reg;
    logic [CNT_W-1:0]              entry_count_reg;

    // Result load request from the sequencer
    logic                          out_load;
    logic [WORD_W-1:0]             out_value;
    logic [lsr_pkg::STATUS_W-1:0]  out_status;
    logic [CNT_W-1:0]              out_count;

    // RAM ports
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [WORD_W-1:0]             wr_data;
    logic                          rd_a_en, rd_b_en;
    logic [ADDR_W-1:0]             rd_a_addr, rd_b_addr;
    logic [WORD_W-1:0]             rd_a_data, rd_b_data;

    logic                          in_acc;
    logic [lsr_pkg::REQ_W-1:0]     req_type;
    logic [CNT_W-1:0]              count_dec;
    logic [CNT_W-1:0]              hi_dec;

    lsr_ram #(
        .DEPTH  (lsr_pkg::STACK_DEPTH),
        .DATA_W (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_en   (rd_b_en),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    // Take a new request only when idle and the output register is free or frees up this
    // cycle; every request then finds an empty output slot when it finishes.
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign in_acc    = s_tvalid && s_tready;
    assign req_type  = s_tuser;
    assign count_dec = count_reg - CNT_W'(1);
    assign hi_dec    = hi_reg - CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        out_load   = 1'b0;
        out_value  = '0;
        out_status = lsr_pkg::STAT_DONE;
        out_count  = count_reg;
        wr_en      = 1'b0;
        wr_addr    = lo_reg[ADDR_W-1:0];
        wr_data    = rd_b_data;
        rd_a_en    = 1'b0;
        rd_b_en    = 1'b0;
        rd_a_addr  = lo_reg[ADDR_W-1:0];
        rd_b_addr  = hi_dec[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (req_type)
                        lsr_pkg::REQ_PUSH: begin
                            out_load = 1'b1;
                            if (count_reg == CNT_W'(lsr_pkg::STACK_DEPTH)) begin
                                // Full: drop the word, keep the count
                                out_status = lsr_pkg::STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[ADDR_W-1:0];
                                wr_data    = s_tdata;
                                count_next = count_reg + CNT_W'(1);
                                out_count  = count_reg + CNT_W'(1);
                            end
                        end
                        lsr_pkg::REQ_POP: begin
                            if (count_reg == '0) begin
                                // Empty: answer all ones at once
                                out_load   = 1'b1;
                                out_value  = '1;
                                out_status = lsr_pkg::STAT_EMPTY;
                            end else begin
                                // Fetch the top word; ST_POP_WAIT loads it into the output register
                                rd_a_en    = 1'b1;
                                rd_a_addr  = count_dec[ADDR_W-1:0];
                                count_next = count_dec;
                                state_next = ST_POP_WAIT;
                            end
                        end
                        lsr_pkg::REQ_REVERSE: begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = ST_REV_STEP;
                        end
                        default: begin
                            // Unused code: no state change, plain done result
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_WAIT: begin
                out_load   = 1'b1;
                out_value  = rd_a_data;
                state_next = ST_IDLE;
            end
            ST_REV_STEP: begin
                if ((lo_reg + CNT_W'(1)) < hi_reg) begin
                    // Read both words of the outer pair together over both ports
                    rd_a_en    = 1'b1;
                    rd_b_en    = 1'b1;
                    hi_next    = hi_dec;
                    state_next = ST_REV_WLO;
                end else begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REV_WLO: begin
                // Upper word goes to the lower slot
                wr_en      = 1'b1;
                wr_addr    = lo_reg[ADDR_W-1:0];
                wr_data    = rd_b_data;
                state_next = ST_REV_WHI;
            end
            ST_REV_WHI: begin
                // Lower word goes to the upper slot, then advance inward
                wr_en      = 1'b1;
                wr_addr    = hi_reg[ADDR_W-1:0];
                wr_data    = rd_a_data;
                lo_next    = lo_reg + CNT_W'(1);
                state_next = ST_REV_STEP;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (out_load) begin
            pop_value_reg   <= out_value;
            status_reg      <= out_status;
            entry_count_reg <= out_count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lsr_pkg::M_TDATA_W - WORD_W - lsr_pkg::ENTRY_COUNT_W){1'b0}},
                       lsr_pkg::ENTRY_COUNT_W'(entry_count_reg),
                       pop_value_reg};
    assign m_tuser  = status_reg;

    `LSR_ASSERT_NOW(a_count_bound, 1'b1,
        count_reg <= CNT_W'(lsr_pkg::STACK_DEPTH), "stack count exceeds depth")
    `LSR_ASSERT_NOW(a_empty_value, m_valid_reg && (status_reg == lsr_pkg::STAT_EMPTY),
        pop_value_reg == '1, "empty pop result is not all ones")
    `LSR_ASSERT_NEXT(a_push_grows,
        in_acc && (req_type == lsr_pkg::REQ_PUSH) &&
        (count_reg != CNT_W'(lsr_pkg::STACK_DEPTH)),
        count_reg == ($past(count_reg) + CNT_W'(1)), "accepted push did not grow stack")
    `LSR_ASSERT_NOW(a_swap_order, state_reg == ST_REV_WLO,
        lo_reg < hi_reg, "reverse swap indices crossed")
    `LSR_ASSERT_NOW(a_idle_out_free, state_reg != ST_IDLE,
        !s_tready, "request accepted while sequencer busy")

endmodule

`default_nettype wire

@@ hdl/lsr_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No package dependencies.
`default_nettype none

module lsr_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_a_en,
    input  wire logic [ADDR_W-1:0] rd_a_addr,
    output logic      [DATA_W-1:0] rd_a_data,
    input  wire logic              rd_b_en,
    input  wire logic [ADDR_W-1:0] rd_b_addr,
    output logic      [DATA_W-1:0] rd_b_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read on that port
    always_ff @(posedge aclk) begin
        if (rd_a_en) begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (rd_b_en) begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

`default_nettype wire
